>>> rtl/core/scpr_pkg.sv
`default_nettype none

package scpr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 20;

  localparam int CFG_W   = 5;
  localparam int SLOT_W  = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic scan;
    logic hit_mark;
    logic shift_start;
    logic shift_rd;
    logic shift_wr;
    logic append;
    logic evict_step;
    logic out_load;
  } scpr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic page_zero;
    logic filled_zero;
    logic cmp_hit;
    logic cmp_last;
    logic append_ok;
    logic hand_zero;
    logic shift_last;
    logic evict_done;
  } scpr_status_t;

endpackage : scpr_pkg

`default_nettype wire

>>> rtl/core/scpr_datapath.sv
`default_nettype none

module scpr_datapath
  import scpr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_wr_data,
  input  wire logic [PAGE_BITS-1:0] page_number,
  input  wire scpr_cmd_t            cmd,
  output scpr_status_t              status,
  output logic                      page_fault,
  output logic [SLOT_W-1:0]         frame_slot
);

  localparam int HAND_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FILL_W = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  // page store, one write and one registered read per cycle
  logic [PAGE_BITS-1:0]  frame_pages [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  rd_data;
  logic [HAND_W-1:0]     rd_addr;
  logic                  mem_we;
  logic [HAND_W-1:0]     mem_wa;
  logic [PAGE_BITS-1:0]  mem_wd;

  logic [MAX_FRAMES-1:0] ref_bits;
  logic [FILL_W-1:0]     filled;
  logic [HAND_W-1:0]     hand;
  logic [CFG_W-1:0]      frames_in_use;

  logic [PAGE_BITS-1:0]  req_page;
  logic [HAND_W-1:0]     walk;
  logic [HAND_W-1:0]     walk_dec;
  logic [HAND_W-1:0]     cmp_idx;
  logic                  cmp_valid;

  logic                  res_fault;
  logic [HAND_W-1:0]     res_slot;

  logic [HAND_W-1:0]     append_tgt;
  logic [HAND_W-1:0]     evict_h;
  logic [FILL_W-1:0]     evict_inc;
  logic [HAND_W-1:0]     evict_hand_next;
  logic                  under_limit;

  assign walk_dec   = walk - HAND_W'(1);
  assign rd_addr    = cmd.shift_rd ? walk_dec : walk;
  assign append_tgt = (hand == '0) ? HAND_W'(filled) : hand;

  // hand is brought back into the filled range before the sweep looks at it
  assign evict_h         = (FILL_W'(hand) >= filled) ? '0 : hand;
  assign evict_inc       = FILL_W'(evict_h) + FILL_W'(1);
  assign evict_hand_next = (evict_inc >= filled) ? '0 : HAND_W'(evict_inc);

  // limit saturates to 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      under_limit = (filled == '0);
    end else begin
      under_limit = (LIM_W'(filled) < LIM_W'(frames_in_use));
    end
    if (filled == FILL_W'(MAX_FRAMES)) begin
      under_limit = 1'b0;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = append_tgt;
    mem_wd = req_page;
    if (cmd.shift_wr) begin
      mem_we = 1'b1;
      mem_wa = walk;
      mem_wd = rd_data;
    end else if (cmd.append) begin
      mem_we = 1'b1;
      mem_wa = append_tgt;
    end else if (cmd.evict_step && !ref_bits[evict_h]) begin
      mem_we = 1'b1;
      mem_wa = evict_h;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_pages[mem_wa] <= mem_wd;
    end
    rd_data <= frame_pages[rd_addr];
  end

  always_comb begin
    status.page_zero   = (page_number == '0);
    status.filled_zero = (filled == '0);
    status.cmp_hit     = cmp_valid && (rd_data == req_page);
    status.cmp_last    = cmp_valid && ((FILL_W'(cmp_idx) + FILL_W'(1)) == filled);
    status.append_ok   = under_limit;
    status.hand_zero   = (hand == '0);
    status.shift_last  = (walk_dec == hand);
    status.evict_done  = !ref_bits[evict_h];
  end

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_bits      <= '0;
      filled        <= '0;
      hand          <= '0;
      frames_in_use <= CFG_RESET;
    end else begin
      if (cfg_wr_en) begin
        frames_in_use <= cfg_wr_data;
      end
      if (cmd.hit_mark) begin
        ref_bits[cmp_idx] <= 1'b1;
      end else if (cmd.shift_wr) begin
        ref_bits[walk] <= ref_bits[walk_dec];
      end else if (cmd.append) begin
        ref_bits[append_tgt] <= 1'b0;
        filled               <= filled + FILL_W'(1);
        if (hand != '0) begin
          hand <= hand + HAND_W'(1);
        end
      end else if (cmd.evict_step) begin
        ref_bits[evict_h] <= 1'b0;
        hand              <= evict_hand_next;
      end
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      walk      <= '0;
    end else begin
      if (cmd.load_req) begin
        cmp_valid <= 1'b0;
        walk      <= '0;
      end else if (cmd.shift_start) begin
        cmp_valid <= 1'b0;
        walk      <= HAND_W'(filled);
      end else if (cmd.scan) begin
        cmp_valid <= 1'b1;
        walk      <= walk + HAND_W'(1);
      end else if (cmd.shift_wr) begin
        walk      <= walk_dec;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_page  <= page_number;
      res_fault <= 1'b0;
      res_slot  <= '0;
    end else if (cmd.hit_mark) begin
      res_fault <= 1'b0;
      res_slot  <= cmp_idx;
    end else if (cmd.append) begin
      res_fault <= 1'b1;
      res_slot  <= append_tgt;
    end else if (cmd.evict_step && !ref_bits[evict_h]) begin
      res_fault <= 1'b1;
      res_slot  <= evict_h;
    end
    if (cmd.scan) begin
      cmp_idx <= walk;
    end
    if (cmd.out_load) begin
      page_fault <= res_fault;
      frame_slot <= SLOT_W'(res_slot);
    end
  end

endmodule : scpr_datapath

`default_nettype wire

>>> rtl/core/scpr_controller.sv
`default_nettype none

module scpr_controller
  import scpr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  output logic              res_valid,
  input  wire logic         res_stall,
  input  wire scpr_status_t status,
  output scpr_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_EVICT,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_stall = (state != ST_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          if (status.page_zero) begin
            state_next = ST_RESULT;
          end else if (status.filled_zero) begin
            state_next = ST_PLACE;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        cmd.scan = 1'b1;
        if (status.cmp_hit) begin
          cmd.hit_mark = 1'b1;
          state_next   = ST_RESULT;
        end else if (status.cmp_last) begin
          // miss: append behind the hand, or sweep for a victim
          if (!status.append_ok) begin
            state_next = ST_EVICT;
          end else if (status.hand_zero) begin
            state_next = ST_PLACE;
          end else begin
            cmd.shift_start = 1'b1;
            state_next      = ST_SHIFT_RD;
          end
        end
      end
      ST_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = status.shift_last ? ST_PLACE : ST_SHIFT_RD;
      end
      ST_PLACE: begin
        cmd.append = 1'b1;
        state_next = ST_RESULT;
      end
      ST_EVICT: begin
        cmd.evict_step = 1'b1;
        if (status.evict_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule : scpr_controller

`default_nettype wire

>>> rtl/core/second_chance_page_replacer_core.sv
`default_nettype none

// channel   signals                     payload
// request   req_valid / req_stall       page_number
// result    res_valid / res_stall       page_fault, frame_slot
// config    cfg_wr_en                   cfg_wr_data (frames in use)
//
// one request at a time; the page store is scanned one slot a cycle through its
// registered read port, so a hit stops the scan at its slot and a miss scans every
// filled slot; a zero page skips the scan; a fill moves each entry past the hand,
// an eviction sweeps past referenced pages, clearing each (at most the filled count)
// reset clears the hand, filled count and referenced bits and sets the limit to 16
// a stalled result holds in the output register while the next request is taken

module second_chance_page_replacer_core
  import scpr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_wr_data,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [PAGE_BITS-1:0] page_number,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic                      page_fault,
  output logic [SLOT_W-1:0]         frame_slot
);

  scpr_cmd_t    cmd;
  scpr_status_t status;

  scpr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  scpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .page_number (page_number),
    .cmd         (cmd),
    .status      (status),
    .page_fault  (page_fault),
    .frame_slot  (frame_slot)
  );

endmodule : second_chance_page_replacer_core

`default_nettype wire

>>> tb/sv/second_chance_page_replacer_core_tb.sv
`timescale 1ns / 100ps

module second_chance_page_replacer_core_tb;
  import scpr_pkg::*;

  localparam int FRAMES = MAX_FRAMES_DEF;
  localparam int PAGE_W = PAGE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 120;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic              fault;
    logic [SLOT_W-1:0] slot;
  } page_result_t;

  typedef enum logic {ROW_PAGE, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [PAGE_W-1:0] value;
    logic              typed;
    page_result_t      want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [PAGE_W-1:0] page_number = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic              page_fault;
  logic [SLOT_W-1:0] frame_slot;

  // predictor state
  logic [PAGE_W-1:0] resident_page [FRAMES];
  logic              ref_bit [FRAMES];
  int                filled_cnt = 0;
  int                hand = 0;
  logic [CFG_W-1:0]  limit_reg = CFG_RESET;

  page_result_t      expected_results [$];
  logic [PAGE_W-1:0] page_pool [$];
  int                mismatch_count = 0;
  int                idle_cycles = 0;
  int                hold_cycles = 0;
  bit                hold_request = 1'b0;
  bit                calm = 1'b0;

  // directed requests; typed results only where they are plain to read off
  stim_row_t directed_rows [22] = '{
    '{ROW_PAGE,  20'h00000, 1'b1, '{1'b0, 4'd0}},
    '{ROW_PAGE,  20'h00001, 1'b1, '{1'b1, 4'd0}},
    '{ROW_PAGE,  20'hFFFFF, 1'b1, '{1'b1, 4'd1}},
    '{ROW_PAGE,  20'h00001, 1'b1, '{1'b0, 4'd0}},
    '{ROW_PAGE,  20'hFFFFF, 1'b1, '{1'b0, 4'd1}},
    '{ROW_PAGE,  20'h00000, 1'b1, '{1'b0, 4'd0}},
    '{ROW_PAGE,  20'hAAAAA, 1'b1, '{1'b1, 4'd2}},
    '{ROW_PAGE,  20'h55555, 1'b1, '{1'b1, 4'd3}},
    '{ROW_LIMIT, 20'd0,     1'b0, '0},
    '{ROW_PAGE,  20'h80000, 1'b0, '0},
    '{ROW_PAGE,  20'h00001, 1'b0, '0},
    '{ROW_PAGE,  20'h7FFFF, 1'b0, '0},
    '{ROW_LIMIT, 20'd31,    1'b0, '0},
    '{ROW_PAGE,  20'h12345, 1'b0, '0},
    '{ROW_PAGE,  20'h23456, 1'b0, '0},
    '{ROW_PAGE,  20'hAAAAA, 1'b0, '0},
    '{ROW_LIMIT, 20'd16,    1'b0, '0},
    '{ROW_PAGE,  20'h0FFFF, 1'b0, '0},
    '{ROW_LIMIT, 20'd2,     1'b0, '0},
    '{ROW_PAGE,  20'h34567, 1'b0, '0},
    '{ROW_LIMIT, 20'd17,    1'b0, '0},
    '{ROW_PAGE,  20'h56789, 1'b0, '0}
  };

  second_chance_page_replacer_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .page_number (page_number),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .page_fault  (page_fault),
    .frame_slot  (frame_slot)
  );

  always #5 clk = ~clk;

  function automatic int active_limit();
    if (limit_reg < 1) return 1;
    if (limit_reg > FRAMES) return FRAMES;
    return int'(limit_reg);
  endfunction

  // second-chance replacement on the predictor's copy of the frame table
  function automatic page_result_t replace_page(input logic [PAGE_W-1:0] pg);
    page_result_t r;
    int s;
    r = '0;
    if (pg == '0) return r;
    for (int i = 0; i < filled_cnt; i++) begin
      if (resident_page[i] == pg) begin
        ref_bit[i] = 1'b1;
        r.slot = SLOT_W'(i);
        return r;
      end
    end
    if (filled_cnt < active_limit()) begin
      if (hand == 0) begin
        s = filled_cnt;
      end else begin
        // new page goes to the back of the fifo, just behind the hand
        for (int i = filled_cnt; i > hand; i--) begin
          resident_page[i] = resident_page[i-1];
          ref_bit[i] = ref_bit[i-1];
        end
        s = hand;
        hand++;
      end
      filled_cnt++;
    end else begin
      if (hand >= filled_cnt) hand = 0;
      while (ref_bit[hand]) begin
        ref_bit[hand] = 1'b0;
        hand++;
        if (hand >= filled_cnt) hand = 0;
      end
      s = hand;
      hand++;
      if (hand >= filled_cnt) hand = 0;
    end
    resident_page[s] = pg;
    ref_bit[s] = 1'b0;
    r.fault = 1'b1;
    r.slot = SLOT_W'(s);
    return r;
  endfunction

  task automatic offer_page(input logic [PAGE_W-1:0] pg, input bit use_typed,
                            input page_result_t typed);
    page_result_t predicted;
    if (!calm) begin
      while ($urandom_range(0, 99) < 34) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    page_number <= pg;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = replace_page(pg);
    expected_results.push_back(use_typed ? typed : predicted);
  endtask

  // also the point where the sender waits for every outstanding result
  task automatic set_frame_limit(input logic [CFG_W-1:0] v);
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  function automatic logic [PAGE_W-1:0] pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 14) return PAGE_W'($urandom);
    return page_pool[$urandom_range(0, page_pool.size() - 1)];
  endfunction

  // receiver: random stalls, a calm stretch and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      res_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      res_stall <= 1'b1;
      hold_cycles <= LONG_HOLD;
    end else if (calm) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < 34);
    end
  end

  always @(posedge clk) begin
    page_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: fault=%0b slot=%0d", page_fault, frame_slot);
      end else begin
        want = expected_results.pop_front();
        if (page_fault !== want.fault || frame_slot !== want.slot) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: expected fault=%0b slot=%0d, got fault=%0b slot=%0d",
                     $realtime, want.fault, want.slot, page_fault, frame_slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_limits [8];
    int pool_size;
    for (int i = 0; i < FRAMES; i++) begin
      resident_page[i] = '0;
      ref_bit[i] = 1'b0;
    end
    phase_limits = '{5'd1, 5'd16, 5'd0, 5'd31, CFG_W'($urandom_range(2, 15)), 5'd17,
                     CFG_W'($urandom_range(2, 15)), 5'd8};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_LIMIT)
        set_frame_limit(CFG_W'(directed_rows[k].value));
      else
        offer_page(directed_rows[k].value, directed_rows[k].typed, directed_rows[k].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      set_frame_limit(phase_limits[ph]);
      calm = (ph == 3);
      if (ph == 1) hold_request = 1'b1;
      // pool of up to twice the limit plus three pages, so hits and evictions both can happen
      page_pool.delete();
      pool_size = $urandom_range(1, 2 * active_limit() + 3);
      for (int i = 0; i < pool_size; i++)
        page_pool.push_back(($urandom_range(0, 3) == 0) ? PAGE_W'($urandom_range(1, 40))
                                                        : PAGE_W'($urandom_range(1, 20'hFFFFF)));
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer_page(pick_page(), 1'b0, '0);
    end

    req_valid <= 1'b0;
    calm = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    mismatch_count += expected_results.size();
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/scpr_pkg.sv
rtl/core/scpr_datapath.sv
rtl/core/scpr_controller.sv
rtl/core/second_chance_page_replacer_core.sv
tb/sv/second_chance_page_replacer_core_tb.sv
